[rtl/ltd_pkg.sv]
`timescale 1ns / 1ps

package ltd_pkg;

    // field and coefficient formats
    localparam int FIELD_WIDTH     = 32;
    localparam int COEF_WIDTH      = 24;
    localparam int STEP_FRAC       = 24;
    localparam int GAIN_FRAC       = 16;
    localparam int ACC_WIDTH       = COEF_WIDTH + 2;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    // register reset values
    localparam logic [COEF_WIDTH-1:0] STEP_RESET = 24'd167772;
    localparam logic [COEF_WIDTH-1:0] GAIN_RESET = 24'd4144861;

    // register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_STEP_SIZE    = 2'd0,
        REG_DAMPING_GAIN = 2'd1
    } cfg_index_t;

    // multiplier control and status
    typedef struct packed {
        logic start;
        logic step_frac;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // width of the rounded product for a given operand width
    function automatic int mul_res_width(input int op_width);
        return ACC_WIDTH + op_width - GAIN_FRAC + 1;
    endfunction

endpackage

[rtl/linear_tracking_differentiator_unit.sv]
`timescale 1ns / 1ps

// Second-order linear tracking differentiator, one result item per input item.
// Input channel (in_valid/in_ready) carries sample, restart and the init
// values; output channel (out_valid/out_ready) carries position, velocity and
// the saturated flag. step_size (index 0) and damping_gain (index 1) are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// The three products of a step run one after another through a single
// bit-serial shift-add multiplier that takes one operand bit per cycle,
// MW = max(DATA_WIDTH, 32) + 1 bits per product. No new item is taken
// until the previous one has run through all three products and been
// loaded into the output register; the pace is set by the serial multiplier.
// A finished result sits in the output register; the next item is taken
// while it waits. If the receiver stalls past the next item's end, the
// block holds that item until the output register frees up.
// Reset clears the tracked state to zero and loads the register defaults.
module linear_tracking_differentiator_unit #(
    parameter int DATA_WIDTH = ltd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ltd_pkg::FIELD_WIDTH-1:0] sample,
    input  logic                                   restart,
    input  logic signed [ltd_pkg::FIELD_WIDTH-1:0] init_position,
    input  logic signed [ltd_pkg::FIELD_WIDTH-1:0] init_velocity,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ltd_pkg::FIELD_WIDTH-1:0] position,
    output logic signed [ltd_pkg::FIELD_WIDTH-1:0] velocity,
    output logic                                   saturated,
    input  logic                                   cfg_we,
    input  logic [ltd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [ltd_pkg::COEF_WIDTH-1:0]         cfg_data
);
    import ltd_pkg::*;

    localparam int MW = ((DATA_WIDTH > FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH) + 1;
    localparam int RW = mul_res_width(MW);
    localparam int UW = RW + 2;
    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_GAIN,
        S_DX1,
        S_DX2,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [COEF_WIDTH-1:0]           step_size_reg;
    logic [COEF_WIDTH-1:0]           damping_gain_reg;
    logic signed [DATA_WIDTH-1:0]    x1_reg;
    logic signed [DATA_WIDTH-1:0]    x2_reg;
    logic signed [DATA_WIDTH-1:0]    u_reg;
    logic signed [FIELD_WIDTH-1:0]   sample_reg;
    logic                            sat_reg;
    mul_ctrl_t                       mctrl_reg;
    logic [COEF_WIDTH-1:0]           coef_reg;
    logic signed [MW-1:0]            op_reg;
    logic                            out_valid_reg;
    logic signed [FIELD_WIDTH-1:0]   position_reg;
    logic signed [FIELD_WIDTH-1:0]   velocity_reg;
    logic                            saturated_reg;

    mul_stat_t                       mstat;
    logic signed [RW-1:0]            mres;
    logic signed [MW-1:0]            err;
    logic signed [UW-1:0]            u_sum;
    logic signed [UW-1:0]            x1_sum;
    logic signed [UW-1:0]            x2_sum;
    logic [DATA_WIDTH:0]             u_sat;
    logic [DATA_WIDTH:0]             x1_sat;
    logic [DATA_WIDTH:0]             x2_sat;
    logic [DATA_WIDTH:0]             ipos_sat;
    logic [DATA_WIDTH:0]             ivel_sat;
    logic                            out_free;

    // clamp to the state range, clamp flag in the top bit
    function automatic logic [DATA_WIDTH:0] sat_dw(input logic signed [UW-1:0] val);
        logic [DATA_WIDTH:0] res;
        if (val > UW'(DMAX))
            res = {1'b1, DMAX};
        else if (val < UW'(DMIN))
            res = {1'b1, DMIN};
        else
            res = {1'b0, val[DATA_WIDTH-1:0]};
        return res;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg    <= STEP_RESET;
            damping_gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SIZE:    step_size_reg    <= cfg_data;
                REG_DAMPING_GAIN: damping_gain_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // shared bit-serial multiplier
    ltd_serial_mul #(
        .OP_WIDTH (MW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mctrl_reg),
        .coef    (coef_reg),
        .operand (op_reg),
        .stat    (mstat),
        .result  (mres)
    );

    // tracking error and the three state sums
    assign err      = MW'(x1_reg) - MW'(sample_reg);
    assign u_sum    = -UW'(mres) - UW'(x2_reg);
    assign x1_sum   = UW'(x1_reg) + UW'(mres);
    assign x2_sum   = UW'(x2_reg) + UW'(mres);
    assign u_sat    = sat_dw(u_sum);
    assign x1_sat   = sat_dw(x1_sum);
    assign x2_sat   = sat_dw(x2_sum);
    assign ipos_sat = sat_dw(UW'(init_position));
    assign ivel_sat = sat_dw(UW'(init_velocity));

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // step sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x1_reg        <= '0;
            x2_reg        <= '0;
            u_reg         <= '0;
            sample_reg    <= '0;
            sat_reg       <= 1'b0;
            mctrl_reg     <= '0;
            coef_reg      <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            velocity_reg  <= '0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            mctrl_reg.start <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample;
                        if (restart)
                        begin
                            x1_reg  <= ipos_sat[DATA_WIDTH-1:0];
                            x2_reg  <= ivel_sat[DATA_WIDTH-1:0];
                            sat_reg <= ipos_sat[DATA_WIDTH] | ivel_sat[DATA_WIDTH];
                        end
                        else
                        begin
                            sat_reg <= 1'b0;
                        end
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    op_reg    <= err;
                    coef_reg  <= damping_gain_reg;
                    mctrl_reg <= '{start: 1'b1, step_frac: 1'b0};
                    state_reg <= S_GAIN;
                end
                S_GAIN:
                begin
                    if (mstat.done)
                    begin
                        u_reg     <= u_sat[DATA_WIDTH-1:0];
                        sat_reg   <= sat_reg | u_sat[DATA_WIDTH];
                        op_reg    <= MW'(x2_reg);
                        coef_reg  <= step_size_reg;
                        mctrl_reg <= '{start: 1'b1, step_frac: 1'b1};
                        state_reg <= S_DX1;
                    end
                end
                S_DX1:
                begin
                    if (mstat.done)
                    begin
                        x1_reg    <= x1_sat[DATA_WIDTH-1:0];
                        sat_reg   <= sat_reg | x1_sat[DATA_WIDTH];
                        op_reg    <= MW'(u_reg);
                        mctrl_reg <= '{start: 1'b1, step_frac: 1'b1};
                        state_reg <= S_DX2;
                    end
                end
                S_DX2:
                begin
                    if (mstat.done)
                    begin
                        x2_reg    <= x2_sat[DATA_WIDTH-1:0];
                        sat_reg   <= sat_reg | x2_sat[DATA_WIDTH];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        position_reg  <= FIELD_WIDTH'(x1_reg);
                        velocity_reg  <= FIELD_WIDTH'(x2_reg);
                        saturated_reg <= sat_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign velocity  = velocity_reg;
    assign saturated = saturated_reg;

    // a product completes only while a step waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mstat.done |-> (state_reg == S_GAIN || state_reg == S_DX1 || state_reg == S_DX2))
    else $error("multiplier finished outside a product wait state");

    // a product is never started over one still running
    assert property (@(posedge clk) disable iff (!rst_n)
        mctrl_reg.start |-> !mstat.busy)
    else $error("multiplier started while busy");

    // no new item while the multiplier is working
    assert property (@(posedge clk) disable iff (!rst_n)
        mstat.busy |-> !in_ready)
    else $error("input ready while multiplier busy");

    // a waiting result is loaded once the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> out_valid_reg && state_reg == S_IDLE)
    else $error("result not presented after step end");

endmodule

[rtl/ltd_serial_mul.sv]
`timescale 1ns / 1ps

module ltd_serial_mul #(
    parameter int OP_WIDTH = 33,
    localparam int RES_WIDTH = ltd_pkg::mul_res_width(OP_WIDTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ltd_pkg::mul_ctrl_t                ctrl,
    input  logic [ltd_pkg::COEF_WIDTH-1:0]    coef,
    input  logic signed [OP_WIDTH-1:0]        operand,
    output ltd_pkg::mul_stat_t                stat,
    output logic signed [RES_WIDTH-1:0]       result
);
    import ltd_pkg::*;

    localparam int PW = ACC_WIDTH + OP_WIDTH;
    localparam int CW = $clog2(OP_WIDTH);

    logic signed [ACC_WIDTH-1:0] coef_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic [OP_WIDTH-1:0]         low_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic                        fin_reg;
    logic                        done_reg;
    logic                        frac_reg;
    logic signed [RES_WIDTH-1:0] result_reg;

    logic                        last_bit;
    logic signed [ACC_WIDTH-1:0] addend;
    logic signed [ACC_WIDTH-1:0] sum;
    logic signed [PW-1:0]        prod;
    logic signed [PW-GAIN_FRAC-1:0] prod_gain;
    logic signed [PW-STEP_FRAC-1:0] prod_step;
    logic signed [RES_WIDTH-1:0] rounded;

    // one multiplier bit per cycle, lsb first, sign bit weighs negative
    assign last_bit = (cnt_reg == '0);
    always_comb
    begin
        if (!low_reg[0])
            addend = '0;
        else if (last_bit)
            addend = -coef_reg;
        else
            addend = coef_reg;
    end
    assign sum = acc_reg + addend;

    // round half up: floor of the shifted product plus the bit below the cut
    assign prod      = $signed({acc_reg, low_reg});
    assign prod_gain = prod[PW-1:GAIN_FRAC];
    assign prod_step = prod[PW-1:STEP_FRAC];
    always_comb
    begin
        if (frac_reg)
            rounded = RES_WIDTH'(prod_step) + RES_WIDTH'(prod[STEP_FRAC-1]);
        else
            rounded = RES_WIDTH'(prod_gain) + RES_WIDTH'(prod[GAIN_FRAC-1]);
    end

    // shift-add sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= '0;
            acc_reg    <= '0;
            low_reg    <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            frac_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                coef_reg <= $signed({2'b00, coef});
                acc_reg  <= '0;
                low_reg  <= operand;
                cnt_reg  <= CW'(OP_WIDTH - 1);
                frac_reg <= ctrl.step_frac;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= sum >>> 1;
                low_reg <= {sum[0], low_reg[OP_WIDTH-1:1]};
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else if (fin_reg)
            begin
                result_reg <= rounded;
                fin_reg    <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    assign stat   = '{busy: busy_reg | fin_reg, done: done_reg};
    assign result = result_reg;

endmodule
